// ----- rtl/core/maf_pkg.sv -----
// Package for the moving average filter: sizes, register indexes and the
// command/status structs that join the controller and the datapath.
// No dependencies.
package maf_pkg;

   // Storage and sample sizes
   localparam int DEPTH       = 128;
   localparam int SAMPLE_BITS = 16;

   // Derived widths
   localparam int SLOT_BITS    = $clog2(DEPTH);
   localparam int WIN_BITS     = $clog2(DEPTH + 1);
   localparam int SUM_BITS     = SAMPLE_BITS + SLOT_BITS;
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

   // Register file sizes
   localparam int WINDOW_REG_BITS = 8;
   localparam int START_BITS      = 16;
   localparam int CSR_INDEX_BITS  = 8;
   localparam int CSR_DATA_BITS   = 16;
   localparam int MIN_WINDOW      = 2;
   localparam int CLAMP_BITS      = (WIN_BITS > WINDOW_REG_BITS) ? WIN_BITS : WINDOW_REG_BITS;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START  = CSR_INDEX_BITS'(2);

   // Controller to datapath
   typedef struct packed {
      logic capture;    // latch the incoming sample
      logic update;     // ring write, running sum update, index advance
      logic div_start;  // launch the divider on the current sum
      logic load_out;   // load the output word
      logic res_ok;     // output word carries a valid average
   } maf_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic enable;
      logic prime_busy;
      logic div_done;
   } maf_status_type;

endpackage

// ----- rtl/core/maf_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on maf_pkg.
module maf_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [maf_pkg::SUM_BITS-1:0]   dividend,
   input  logic [maf_pkg::WIN_BITS-1:0]   divisor,
   output logic [maf_pkg::SUM_BITS-1:0]   quotient,
   output logic                           done
);
   import maf_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic [SUM_BITS-1:0]     quo_ff;
   logic [WIN_BITS-1:0]     rem_ff;
   logic [WIN_BITS-1:0]     div_ff;

   logic [WIN_BITS:0]       trial;
   logic                    fits;
   logic [WIN_BITS-1:0]     rem_in;

   // One shift/subtract step
   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_BITS-1]};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? WIN_BITS'(trial - {1'b0, div_ff}) : WIN_BITS'(trial);
   end

   // Step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_BITS'(SUM_BITS - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - DIV_CNT_BITS'(1);
            end
         end
      end
   end

   // Quotient and remainder shift
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SUM_BITS-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ----- rtl/core/maf_datapath.sv -----
// Datapath of the moving average filter: registers, sample ring, running
// sum, divider and output word. Depends on maf_pkg and maf_divider.
module maf_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [maf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [maf_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic signed [maf_pkg::SAMPLE_BITS-1:0] req_sample,
   input  maf_pkg::maf_cmd_type                  cmd,
   output maf_pkg::maf_status_type               status,
   output logic signed [maf_pkg::SAMPLE_BITS-1:0] rsp_average,
   output logic                                  rsp_valid_res
);
   import maf_pkg::*;

   // Configuration
   logic                          enable_ff;
   logic [WINDOW_REG_BITS-1:0]    window_ff;
   logic signed [START_BITS-1:0]  start_ff;
   logic                          prime_ff;

   // Filter state
   logic [SLOT_BITS-1:0]          slot_ff;
   logic signed [SUM_BITS-1:0]    sum_ff;
   logic [DEPTH-1:0]              valid_ff;
   logic signed [SAMPLE_BITS-1:0] mem_ff [DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          neg_ff;
   logic signed [SAMPLE_BITS-1:0] avg_ff;
   logic                          vres_ff;

   logic [CLAMP_BITS-1:0]         win_raw;
   logic [WIN_BITS-1:0]           win_eff;
   logic [SLOT_BITS-1:0]          slot_eff;
   logic [WIN_BITS-1:0]           slot_inc;
   logic [SLOT_BITS-1:0]          slot_next;
   logic signed [SAMPLE_BITS-1:0] start_sample;
   logic signed [SAMPLE_BITS-1:0] old_sample;
   logic signed [SUM_BITS-1:0]    sum_upd;
   logic signed [START_BITS+WIN_BITS:0] prime_prod;
   logic [SUM_BITS-1:0]           magnitude;
   logic [SUM_BITS-1:0]           quotient;
   logic [SUM_BITS-1:0]           quo_signed;
   logic                          div_done;
   logic                          csr_known;

   // Window clamp and ring index
   always_comb begin
      win_raw = CLAMP_BITS'(window_ff);
      if (win_raw < CLAMP_BITS'(MIN_WINDOW)) begin
         win_eff = WIN_BITS'(MIN_WINDOW);
      end else if (win_raw > CLAMP_BITS'(DEPTH)) begin
         win_eff = WIN_BITS'(DEPTH);
      end else begin
         win_eff = WIN_BITS'(win_raw);
      end
      slot_eff  = (WIN_BITS'(slot_ff) >= win_eff) ? '0 : slot_ff;
      slot_inc  = WIN_BITS'(slot_eff) + WIN_BITS'(1);
      slot_next = (slot_inc >= win_eff) ? '0 : SLOT_BITS'(slot_inc);
   end

   // Running sum; slots not written since priming hold the start value
   always_comb begin
      start_sample = SAMPLE_BITS'(start_ff);
      old_sample   = valid_ff[slot_eff] ? rd_data_ff : start_sample;
      sum_upd      = sum_ff - SUM_BITS'(old_sample) + SUM_BITS'(sample_ff);
      prime_prod   = start_ff * $signed({1'b0, win_eff});
      csr_known    = (csr_index == CSR_ENABLE) || (csr_index == CSR_WINDOW)
                     || (csr_index == CSR_START);
   end

   // Sign handling around the unsigned divider
   always_comb begin
      magnitude  = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
      quo_signed = neg_ff ? SUM_BITS'(-quotient) : quotient;
   end

   // Registers, priming and state update
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         window_ff <= WINDOW_REG_BITS'(MIN_WINDOW);
         start_ff  <= '0;
         prime_ff  <= 1'b0;
         slot_ff   <= '0;
         sum_ff    <= '0;
         valid_ff  <= '0;
      end else begin
         if (csr_valid && csr_known) begin
            unique case (csr_index)
               CSR_ENABLE: enable_ff <= csr_data[0];
               CSR_WINDOW: window_ff <= csr_data[WINDOW_REG_BITS-1:0];
               CSR_START:  start_ff  <= $signed(csr_data[START_BITS-1:0]);
               default: ;
            endcase
            prime_ff <= 1'b1;
            slot_ff  <= '0;
            valid_ff <= '0;
         end else if (prime_ff) begin
            sum_ff   <= SUM_BITS'(prime_prod);
            prime_ff <= 1'b0;
         end else if (cmd.update) begin
            sum_ff             <= sum_upd;
            valid_ff[slot_eff] <= 1'b1;
            slot_ff            <= slot_next;
         end
      end
   end

   // Sample ring
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[slot_eff];
      if (cmd.update) begin
         mem_ff[slot_eff] <= sample_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
      end
      if (cmd.div_start) begin
         neg_ff <= sum_ff[SUM_BITS-1];
      end
      if (cmd.load_out) begin
         avg_ff  <= cmd.res_ok ? $signed(SAMPLE_BITS'(quo_signed)) : '0;
         vres_ff <= cmd.res_ok;
      end
   end

   maf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (magnitude),
      .divisor  (win_eff),
      .quotient (quotient),
      .done     (div_done)
   );

   always_comb begin
      status.enable     = enable_ff;
      status.prime_busy = prime_ff;
      status.div_done   = div_done;
   end

   assign rsp_average   = avg_ff;
   assign rsp_valid_res = vres_ff;

endmodule

// ----- rtl/core/maf_ctrl.sv -----
// Controller of the moving average filter: sequences one word through
// update, divide and output load (load only while disabled). Depends on maf_pkg.
module maf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output maf_pkg::maf_cmd_type    cmd,
   input  maf_pkg::maf_status_type status
);
   import maf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      res_ok_ff;
   logic      accept;
   logic      can_load;

   // Handshake and commands
   always_comb begin
      req_ready     = (state_ff == ST_IDLE) && !status.prime_busy;
      accept        = req_valid && req_ready;
      can_load      = !rsp_valid_ff || rsp_ready;
      cmd.capture   = accept;
      cmd.update    = (state_ff == ST_UPDATE);
      cmd.div_start = (state_ff == ST_START);
      cmd.load_out  = (state_ff == ST_DONE) && can_load;
      cmd.res_ok    = res_ok_ff;
   end

   // State and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         res_ok_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  res_ok_ff <= status.enable;
                  state_ff  <= status.enable ? ST_UPDATE : ST_DONE;
               end
            end
            ST_UPDATE: state_ff <= ST_START;
            ST_START:  state_ff <= ST_DIVIDE;
            ST_DIVIDE: begin
               if (status.div_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (can_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/moving_average_filter.sv -----
// Boxcar moving average: an accepted sample goes through ring update, divider
// start, divider (one quotient bit per cycle) and output load while enabled,
// straight to output load while disabled. The next sample may be accepted once
// the previous result is loaded, also while it waits in the output register.
// Synchronous reset: disabled, window 2, start value 0, ring reads as zero.
// A listed register write re-primes the ring, with req_ready low meanwhile.
module moving_average_filter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [maf_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [maf_pkg::SAMPLE_BITS-1:0] rsp_average,
   output logic                                   rsp_valid_res,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [maf_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [maf_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import maf_pkg::*;

   maf_cmd_type    cmd;
   maf_status_type status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   maf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   maf_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_sample    (req_sample),
      .cmd           (cmd),
      .status        (status),
      .rsp_average   (rsp_average),
      .rsp_valid_res (rsp_valid_res)
   );

endmodule

// ----- rtl/core/maf_checker.sv -----
// Port-level checks for the moving average filter, bound to the top level.
// Depends on maf_pkg and moving_average_filter.
module maf_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [maf_pkg::SAMPLE_BITS-1:0] rsp_average,
   input logic                                   rsp_valid_res,
   input logic                                   csr_valid,
   input logic                                   csr_ready,
   input logic [maf_pkg::CSR_INDEX_BITS-1:0]     csr_index
);
   import maf_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       req_word;
   logic       rsp_word;

   // Words in flight: one computing, one waiting at the output
   always_comb begin
      req_word = req_valid && req_ready;
      rsp_word = rsp_valid && rsp_ready;
      count_in = count_ff + 2'(req_word) - 2'(rsp_word);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average)
                                  && $stable(rsp_valid_res))
      else $error("result word changed while stalled");

   // Disabled results carry a zero average
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_average == '0)
      else $error("invalid result with nonzero average");

   // No result without a sample, at most two words in flight
   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || count_ff != 2'd0) && count_ff != 2'd3)
      else $error("result count does not match accepted samples");

   // A known register write blocks samples for the priming cycle
   a_prime_block: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == CSR_ENABLE || csr_index == CSR_WINDOW
                                 || csr_index == CSR_START) |=> !req_ready)
      else $error("sample accepted during priming");

endmodule

bind moving_average_filter maf_checker u_maf_checker (.*);

// ----- dv/moving_average_filter_tb.sv -----
`timescale 1ns / 100ps
// Testbench for moving_average_filter: a directed table, then randomized phases
// with sender/receiver idling, checked against a local running-sum model or the
// table's typed-in results. Depends on maf_pkg and the filter RTL.
module moving_average_filter_tb;
   import maf_pkg::*;

   localparam int HOLD_CYCLES    = 600;    // long receiver hold-off
   localparam int STALL_LIMIT    = 5000;   // cycles with no handshake at all
   localparam int DRAIN_CYCLES   = 40;     // longer than the result latency
   localparam int PHASES         = 12;
   localparam int PHASE_WORDS    = 75;
   localparam int PRESSURE_PHASE = 5;
   localparam int ROWS           = 27;

   // Indexes past the register list: written, then ignored by the block
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_FIRST = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LAST  = '1;

   typedef enum logic { ROW_SAMPLE, ROW_CSR } row_kind_type;

   // One directed row: a sample word (optionally with a typed-in result) or a
   // register write
   typedef struct packed {
      row_kind_type                kind;
      logic [CSR_INDEX_BITS-1:0]   idx;
      logic [CSR_DATA_BITS-1:0]    data;
      logic                        typed;
      logic signed [SAMPLE_BITS-1:0] avg;
      logic                        vld;
   } dir_row_type;

   // Sample word waiting to be sent, with its typed-in result if any
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          typed;
      logic signed [SAMPLE_BITS-1:0] avg;
      logic                          vld;
   } sample_word_type;

   // Result word as it should come out
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] average;
      logic                          valid_res;
   } avg_word_type;

   localparam dir_row_type DIR_TABLE [ROWS] = '{
      // disabled after reset: zero, flagged invalid
      '{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, 16'sd0, 1'b0},
      '{ROW_SAMPLE, '0, 16'h8000, 1'b1, 16'sd0, 1'b0},
      // write to an index past the list changes nothing
      '{ROW_CSR, CSR_UNUSED_LAST, 16'hFFFF, 1'b0, 16'sd0, 1'b0},
      '{ROW_SAMPLE, '0, 16'd100, 1'b1, 16'sd0, 1'b0},
      // enable, window 2, start 0: full-scale swings
      '{ROW_CSR, CSR_ENABLE, 16'hFFFF, 1'b0, 16'sd0, 1'b0},
      '{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, 16'sd16383, 1'b1},
      '{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, 16'sh7FFF, 1'b1},
      '{ROW_SAMPLE, '0, 16'h8000, 1'b1, 16'sd0, 1'b1},
      '{ROW_SAMPLE, '0, 16'h8000, 1'b1, 16'sh8000, 1'b1},
      '{ROW_SAMPLE, '0, 16'hFFFD, 1'b0, 16'sd0, 1'b0},
      // window below range (low byte 1) acts as 2; -1/2 truncates to zero
      '{ROW_CSR, CSR_WINDOW, 16'hFF01, 1'b0, 16'sd0, 1'b0},
      '{ROW_SAMPLE, '0, 16'hFFFF, 1'b1, 16'sd0, 1'b1},
      // window above range acts as 128, primed with the most negative start
      '{ROW_CSR, CSR_WINDOW, 16'h00FF, 1'b0, 16'sd0, 1'b0},
      '{ROW_CSR, CSR_START, 16'h8000, 1'b0, 16'sd0, 1'b0},
      '{ROW_SAMPLE, '0, 16'h8000, 1'b1, 16'sh8000, 1'b1},
      '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, 16'sd0, 1'b0},
      '{ROW_CSR, CSR_START, 16'h7FFF, 1'b0, 16'sd0, 1'b0},
      '{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, 16'sh7FFF, 1'b1},
      // window 3: index wraps after three words
      '{ROW_CSR, CSR_WINDOW, 16'd3, 1'b0, 16'sd0, 1'b0},
      '{ROW_CSR, CSR_START, 16'd0, 1'b0, 16'sd0, 1'b0},
      '{ROW_SAMPLE, '0, 16'd1, 1'b0, 16'sd0, 1'b0},
      '{ROW_SAMPLE, '0, 16'd2, 1'b0, 16'sd0, 1'b0},
      '{ROW_SAMPLE, '0, 16'd3, 1'b0, 16'sd0, 1'b0},
      '{ROW_SAMPLE, '0, 16'd4, 1'b0, 16'sd0, 1'b0},
      // disable again; second unused index is ignored too
      '{ROW_CSR, CSR_ENABLE, 16'd0, 1'b0, 16'sd0, 1'b0},
      '{ROW_CSR, CSR_UNUSED_FIRST, 16'd1, 1'b0, 16'sd0, 1'b0},
      '{ROW_SAMPLE, '0, 16'd5, 1'b1, 16'sd0, 1'b0}
   };

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample    = '0;
   logic                          rsp_valid;
   logic                          rsp_ready     = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_average;
   logic                          rsp_valid_res;
   logic                          csr_valid     = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index     = '0;
   logic [CSR_DATA_BITS-1:0]      csr_data      = '0;

   moving_average_filter dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_average   (rsp_average),
      .rsp_valid_res (rsp_valid_res),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   sample_word_type sample_feed_q [$];
   avg_word_type    avg_expect_q [$];
   sample_word_type cur_word = '0;   // word currently on the request port
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   logic            hold_go = 1'b0;
   int              err_count = 0;
   int              words_pending = 0;  // queued words whose result is not yet taken

   // Filter model state and registers
   logic signed [SAMPLE_BITS-1:0] ring_mem [DEPTH];
   logic signed [SUM_BITS-1:0]    ring_sum;
   int                            ring_slot;
   logic                          en_q;
   logic [WINDOW_REG_BITS-1:0]    win_q;
   logic signed [START_BITS-1:0]  start_q;

   function automatic int eff_window();
      if (win_q < MIN_WINDOW) return MIN_WINDOW;
      if (win_q > DEPTH) return DEPTH;
      return int'(win_q);
   endfunction

   // Fill every slot with the start value and rebuild the sum
   function automatic void prime_ring();
      for (int i = 0; i < DEPTH; i++) ring_mem[i] = start_q;
      ring_sum  = SUM_BITS'(int'(start_q) * eff_window());
      ring_slot = 0;
   endfunction

   function automatic void reset_filter_model();
      en_q    = 1'b0;
      win_q   = WINDOW_REG_BITS'(MIN_WINDOW);
      start_q = '0;
      prime_ring();
   endfunction

   // Any write to a listed register re-primes; unlisted indexes do nothing
   function automatic void apply_reg_write(input logic [CSR_INDEX_BITS-1:0] idx,
                                           input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_ENABLE: en_q    = data[0];
         CSR_WINDOW: win_q   = data[WINDOW_REG_BITS-1:0];
         CSR_START:  start_q = data[START_BITS-1:0];
         default:    return;
      endcase
      prime_ring();
   endfunction

   // Running-sum update for one sample, quotient truncated toward zero
   function automatic avg_word_type next_average(input logic signed [SAMPLE_BITS-1:0] s);
      avg_word_type r;
      int           w;
      int           slot;
      r = '0;
      if (!en_q) return r;
      w    = eff_window();
      slot = (ring_slot >= w) ? 0 : ring_slot;
      ring_sum       = ring_sum - ring_mem[slot] + s;
      ring_mem[slot] = s;
      r.average      = SAMPLE_BITS'(int'(ring_sum) / w);
      r.valid_res    = 1'b1;
      slot++;
      ring_slot = (slot >= w) ? 0 : slot;
      return r;
   endfunction

   // Request driver: holds valid and payload until accepted
   always @(posedge clock) begin : req_drive
      sample_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (sample_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = sample_feed_q.pop_front();
            req_valid  <= 1'b1;
            req_sample <= nxt.sample;
            cur_word   <= nxt;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls plus one long hold-off
   always @(posedge clock) begin : rsp_drive
      int   hold_left;
      logic hold_used;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         hold_used = 1'b0;
      end else if (hold_go && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Handshake monitor: model update, result check, watchdog
   always @(posedge clock) begin : monitor
      avg_word_type want;
      int           quiet_cycles;
      if (reset) begin
         reset_filter_model();
         quiet_cycles = 0;
      end else begin
         if (csr_valid && csr_ready) apply_reg_write(csr_index, csr_data);

         if (req_valid && req_ready) begin
            want = next_average(req_sample);
            if (cur_word.typed) begin
               want.average   = cur_word.avg;
               want.valid_res = cur_word.vld;
            end
            avg_expect_q.push_back(want);
         end

         if (rsp_valid && rsp_ready) begin
            if (avg_expect_q.size() == 0) begin
               err_count++;
               $display("%0t: result word with none expected: average %0d valid_res %0b",
                        $time, rsp_average, rsp_valid_res);
            end else begin
               want = avg_expect_q.pop_front();
               words_pending--;
               if (rsp_average !== want.average) begin
                  err_count++;
                  $display("%0t: average mismatch: expected %0d, actual %0d",
                           $time, want.average, rsp_average);
               end
               if (rsp_valid_res !== want.valid_res) begin
                  err_count++;
                  $display("%0t: valid_res mismatch: expected %0b, actual %0b",
                           $time, want.valid_res, rsp_valid_res);
               end
            end
         end

         if ((csr_valid && csr_ready) || (req_valid && req_ready) ||
             (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Block until every queued word has gone in and its result has come out
   task automatic wait_drained();
      while (words_pending != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      sample_word_type               w;
      logic signed [SAMPLE_BITS-1:0] s;
      logic [WINDOW_REG_BITS-1:0]    win;
      logic [CSR_DATA_BITS-1:0]      en_data;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table, no idling
      foreach (DIR_TABLE[i]) begin
         if (DIR_TABLE[i].kind == ROW_CSR) begin
            wait_drained();
            csr_write(DIR_TABLE[i].idx, DIR_TABLE[i].data);
         end else begin
            w = '{DIR_TABLE[i].data, DIR_TABLE[i].typed, DIR_TABLE[i].avg,
                  DIR_TABLE[i].vld};
            words_pending++;
            sample_feed_q.push_back(w);
         end
      end

      // Random phases: new settings each time, idling mode cycles through four
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase

         // Mostly small windows; now and then the top, over-range or under-range
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: win = WINDOW_REG_BITS'($urandom_range(8, 2));
            6:                win = WINDOW_REG_BITS'($urandom_range(40, 9));
            7:                win = WINDOW_REG_BITS'(DEPTH);
            8:                win = WINDOW_REG_BITS'($urandom_range(255, DEPTH + 1));
            default:          win = WINDOW_REG_BITS'($urandom_range(1, 0));
         endcase
         csr_write(CSR_WINDOW, {8'($urandom_range(255)), win});

         case ($urandom_range(3))
            0:       csr_write(CSR_START, 16'h8000);
            1:       csr_write(CSR_START, 16'h7FFF);
            default: csr_write(CSR_START, CSR_DATA_BITS'($urandom));
         endcase

         en_data    = CSR_DATA_BITS'($urandom);
         en_data[0] = ($urandom_range(5) != 0);
         csr_write(CSR_ENABLE, en_data);

         if ($urandom_range(3) == 0)
            csr_write(CSR_INDEX_BITS'($urandom_range(CSR_UNUSED_LAST, CSR_UNUSED_FIRST)),
                      CSR_DATA_BITS'($urandom));

         // Fill-up phase: receiver holds off while the sender keeps offering
         if (ph == PRESSURE_PHASE) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            hold_go <= 1'b1;
         end

         for (int n = 0; n < PHASE_WORDS; n++) begin
            case ($urandom_range(7))
               0:       s = 16'sh7FFF;
               1:       s = 16'sh8000;
               2:       s = SAMPLE_BITS'($urandom_range(16)) - 16'sd8;
               default: s = SAMPLE_BITS'($urandom);
            endcase
            w = '{s, 1'b0, 16'sd0, 1'b0};
            words_pending++;
            sample_feed_q.push_back(w);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && avg_expect_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
